/* hdl/tfe_pkg.sv */
// tfe_pkg: shared types and constants for the tx frame encoder
// no dependencies; imported by every module under hdl

package tfe_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int STEP_W      = 4;

    localparam logic [7:0] START_BYTE   = 8'h7E;
    localparam logic [7:0] TYPE_TX16    = 8'h01;
    localparam logic [7:0] CHECK_INIT   = 8'hFF;
    localparam logic [8:0] LENGTH_EXTRA = 9'd5;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_DEST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IDENT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_OPTS  = 2'd2;

    // header and payload byte positions
    localparam logic [STEP_W-1:0] STEP_SOF     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LEN_HI  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LEN_LO  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_TYPE    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_IDENT   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DEST_HI = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DEST_LO = 4'd6;
    localparam logic [STEP_W-1:0] STEP_OPTS    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_HDR_CHK = 4'd8;
    localparam logic [STEP_W-1:0] STEP_PAY     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_PAY_CHK = 4'd1;

    typedef struct packed {
        logic       command;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
    } tfe_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } tfe_out_t;

    // one queued job for the back end
    typedef struct packed {
        logic        is_start;
        logic        last;
        logic [7:0]  plen;
        logic [7:0]  data;
        logic [15:0] dest;
        logic [7:0]  ident;
        logic [7:0]  opts;
    } tfe_op_t;

    // queue status toward the back end
    typedef struct packed {
        logic    valid;
        tfe_op_t op;
    } tfe_head_t;

endpackage

/* hdl/tfe_front.sv */
// tfe_front: command intake, frame tracking and configuration registers
// depends on tfe_pkg

module tfe_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    input  logic                             cmd_stall,
    input  tfe_pkg::tfe_in_t                 cmd_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tfe_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             push,
    output tfe_pkg::tfe_op_t                 push_op
);
    import tfe_pkg::*;

    logic        open_reg, open_next;
    logic [7:0]  remain_reg, remain_next;
    logic [15:0] dest_reg, dest_next;
    logic [7:0]  ident_reg, ident_next;
    logic [7:0]  opts_reg, opts_next;
    logic        take;
    logic        is_start;

    assign cfg_ready = 1'b1;
    assign take      = cmd_valid && !cmd_stall;
    assign is_start  = (cmd_data.command == CMD_START);
    // payload outside an open frame is dropped
    assign push      = take && (is_start || open_reg);

    always_comb
    begin
        push_op.is_start = is_start;
        push_op.plen     = cmd_data.payload_length;
        push_op.data     = cmd_data.data_byte;
        push_op.dest     = dest_reg;
        push_op.ident    = ident_reg;
        push_op.opts     = opts_reg;
        push_op.last     = is_start ? (cmd_data.payload_length == 8'd0)
                                    : (remain_reg == 8'd1);
    end

    always_comb
    begin
        open_next   = open_reg;
        remain_next = remain_reg;
        if (take)
        begin
            if (is_start)
            begin
                open_next   = (cmd_data.payload_length != 8'd0);
                remain_next = cmd_data.payload_length;
            end
            else if (open_reg)
            begin
                remain_next = remain_reg - 8'd1;
                open_next   = (remain_reg != 8'd1);
            end
        end
    end

    always_comb
    begin
        dest_next  = dest_reg;
        ident_next = ident_reg;
        opts_next  = opts_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEST:  dest_next  = cfg_data;
                REG_IDENT: ident_next = cfg_data[7:0];
                REG_OPTS:  opts_next  = cfg_data[7:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= 1'b0;
            remain_reg <= 8'd0;
            dest_reg   <= 16'hFFFF;
            ident_reg  <= 8'h01;
            opts_reg   <= 8'h00;
        end
        else
        begin
            open_reg   <= open_next;
            remain_reg <= remain_next;
            dest_reg   <= dest_next;
            ident_reg  <= ident_next;
            opts_reg   <= opts_next;
        end
    end

endmodule

/* hdl/tfe_queue.sv */
// tfe_queue: small register queue of jobs between front and back end
// depends on tfe_pkg

module tfe_queue #(
    parameter int DEPTH = tfe_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tfe_pkg::tfe_op_t   push_op,
    output logic               full,
    input  logic               pop,
    output tfe_pkg::tfe_head_t head
);
    import tfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

    tfe_op_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == CNT_DEPTH);
    assign head.valid = (count_reg != '0);
    assign head.op    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_DEPTH)
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

/* hdl/tfe_back.sv */
// tfe_back: byte sequencer, checksum and output register
// depends on tfe_pkg

module tfe_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tfe_pkg::tfe_head_t head,
    output logic               pop,
    output logic               frm_valid,
    input  logic               frm_stall,
    output tfe_pkg::tfe_out_t  frm_data
);
    import tfe_pkg::*;

    logic                busy_reg, busy_next;
    tfe_op_t             op_reg;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [7:0]          check_reg, check_next;
    logic                out_valid_reg, out_valid_next;
    tfe_out_t            out_reg;

    logic                advance;
    logic                emit;
    logic                is_check;
    logic                summed;
    logic                done;
    logic [8:0]          total;
    logic [7:0]          hdr_byte;
    logic [7:0]          cur_byte;

    assign advance = !out_valid_reg || !frm_stall;
    assign emit    = busy_reg && advance;
    assign total   = {1'b0, op_reg.plen} + LENGTH_EXTRA;

    always_comb
    begin
        unique case (step_reg)
            STEP_SOF:     hdr_byte = START_BYTE;
            STEP_LEN_HI:  hdr_byte = {7'd0, total[8]};
            STEP_LEN_LO:  hdr_byte = total[7:0];
            STEP_TYPE:    hdr_byte = TYPE_TX16;
            STEP_IDENT:   hdr_byte = op_reg.ident;
            STEP_DEST_HI: hdr_byte = op_reg.dest[15:8];
            STEP_DEST_LO: hdr_byte = op_reg.dest[7:0];
            STEP_OPTS:    hdr_byte = op_reg.opts;
            default:      hdr_byte = check_reg;
        endcase
    end

    always_comb
    begin
        if (op_reg.is_start)
        begin
            is_check = (step_reg == STEP_HDR_CHK);
            summed   = !is_check && (step_reg >= STEP_TYPE);
            done     = is_check || (!op_reg.last && step_reg == STEP_OPTS);
            cur_byte = hdr_byte;
        end
        else
        begin
            is_check = (step_reg == STEP_PAY_CHK);
            summed   = !is_check;
            done     = is_check || !op_reg.last;
            cur_byte = is_check ? check_reg : op_reg.data;
        end
    end

    assign pop = head.valid && (!busy_reg || (emit && done));

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        check_next     = check_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            step_next      = step_reg + 1'b1;
            if (op_reg.is_start && step_reg == STEP_SOF)
                check_next = CHECK_INIT;
            else if (summed)
                check_next = check_reg - cur_byte;
            if (done)
                busy_next = 1'b0;
        end
        else if (advance)
            out_valid_next = 1'b0;
        if (pop)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            check_reg     <= CHECK_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            check_reg     <= check_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            op_reg <= head.op;
        if (emit)
        begin
            out_reg.frame_byte <= cur_byte;
            out_reg.frame_end  <= is_check;
        end
    end

    assign frm_valid = out_valid_reg;
    assign frm_data  = out_reg;

    a_hdr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && op_reg.is_start) |-> step_reg <= STEP_HDR_CHK)
        else $error("header step out of range");

    a_pay_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !op_reg.is_start) |-> step_reg <= STEP_PAY_CHK)
        else $error("payload step out of range");

endmodule

/* hdl/api_tx_frame_encoder_unit.sv */
// api_tx_frame_encoder_unit: top level of the tx frame encoder
// depends on tfe_pkg, tfe_front, tfe_queue, tfe_back
//
//   channel | dir | handshake              | content
//   cmd     | in  | cmd_valid / cmd_stall  | command, payload_length, data_byte
//   frm     | out | frm_valid / frm_stall  | frame_byte, frame_end
//   cfg     | in  | cfg_valid / cfg_ready  | register index, write data
//
// one frame byte per cycle leaves the output register; a start produces eight
// header bytes (nine with an empty payload), a payload byte one (two on the last)
// payload bytes transfer one per cycle; the queue of QUEUE_DEPTH jobs fills while
// the back end emits header and checksum bytes, then cmd_stall rises
// frm_stall holds the output register and, through the queue, the command side
// rst_n resets frame tracking, queue and checksum; registers return to defaults

module api_tx_frame_encoder_unit #(
    parameter int QUEUE_DEPTH = tfe_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  tfe_pkg::tfe_in_t                 cmd_data,
    output logic                             frm_valid,
    input  logic                             frm_stall,
    output tfe_pkg::tfe_out_t                frm_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tfe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tfe_pkg::*;

    logic      push;
    tfe_op_t   push_op;
    logic      full;
    logic      pop;
    tfe_head_t head;

    assign cmd_stall = full;

    tfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_op   (push_op)
    );

    tfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (full),
        .pop     (pop),
        .head    (head)
    );

    tfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .frm_valid (frm_valid),
        .frm_stall (frm_stall),
        .frm_data  (frm_data)
    );

endmodule
